[design/sgtr_pkg.sv]
// Shared types, constants and the 5x7 font ROM of the glyph rasterizer.
package sgtr_pkg;

  // Width of the internal coordinate arithmetic: a 16-bit pen plus a cell offset.
  localparam int XW          = 17;
  localparam int PEN_W       = 16;
  localparam int SCALE_W     = 4;
  localparam int GLYPH_COLS  = 5;
  localparam int GLYPH_ROWS  = 7;
  localparam int GLYPH_GAP   = 2;
  localparam int GLYPH_ADV   = GLYPH_COLS + GLYPH_GAP;
  localparam int GLYPH_CELLS = GLYPH_COLS * GLYPH_ROWS;
  localparam int GX_W        = 3;
  localparam int GY_W        = 3;

  // One candidate rectangle for a font cell, before truncation to port width.
  typedef struct packed {
    logic          hit;
    logic [XW-1:0] left;
    logic [XW-1:0] top;
    logic [XW-1:0] right;
    logic [XW-1:0] bottom;
  } rect_t;

  // Font bitmap, top row in the most significant bits, leftmost dot first.
  function automatic logic [GLYPH_CELLS-1:0] glyph_bits(input logic [7:0] ch);
    logic [GLYPH_CELLS-1:0] g;
    g = '0;
    unique case (ch)
      8'h2D: g = {5'd0, 5'd0, 5'd0, 5'd14, 5'd0, 5'd0, 5'd0};
      8'h3A: g = {5'd0, 5'd12, 5'd12, 5'd0, 5'd12, 5'd12, 5'd0};
      8'h2F: g = {5'd1, 5'd2, 5'd4, 5'd4, 5'd8, 5'd16, 5'd16};
      8'h30: g = {5'd14, 5'd17, 5'd19, 5'd21, 5'd25, 5'd17, 5'd14};
      8'h31: g = {5'd4, 5'd12, 5'd4, 5'd4, 5'd4, 5'd4, 5'd14};
      8'h32: g = {5'd14, 5'd17, 5'd1, 5'd2, 5'd4, 5'd8, 5'd31};
      8'h33: g = {5'd30, 5'd1, 5'd1, 5'd14, 5'd1, 5'd1, 5'd30};
      8'h34: g = {5'd2, 5'd6, 5'd10, 5'd18, 5'd31, 5'd2, 5'd2};
      8'h35: g = {5'd31, 5'd16, 5'd16, 5'd30, 5'd1, 5'd1, 5'd30};
      8'h36: g = {5'd6, 5'd8, 5'd16, 5'd30, 5'd17, 5'd17, 5'd14};
      8'h37: g = {5'd31, 5'd1, 5'd2, 5'd4, 5'd8, 5'd8, 5'd8};
      8'h38: g = {5'd14, 5'd17, 5'd17, 5'd14, 5'd17, 5'd17, 5'd14};
      8'h39: g = {5'd14, 5'd17, 5'd17, 5'd15, 5'd1, 5'd2, 5'd28};
      8'h41: g = {5'd14, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
      8'h42: g = {5'd30, 5'd17, 5'd17, 5'd30, 5'd17, 5'd17, 5'd30};
      8'h43: g = {5'd14, 5'd17, 5'd16, 5'd16, 5'd16, 5'd17, 5'd14};
      8'h44: g = {5'd28, 5'd18, 5'd17, 5'd17, 5'd17, 5'd18, 5'd28};
      8'h45: g = {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd31};
      8'h46: g = {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd16};
      8'h47: g = {5'd14, 5'd17, 5'd16, 5'd23, 5'd17, 5'd17, 5'd14};
      8'h48: g = {5'd17, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
      8'h49: g = {5'd14, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd14};
      8'h4C: g = {5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd31};
      8'h4D: g = {5'd17, 5'd27, 5'd21, 5'd21, 5'd17, 5'd17, 5'd17};
      8'h4E: g = {5'd17, 5'd25, 5'd21, 5'd19, 5'd17, 5'd17, 5'd17};
      8'h4F: g = {5'd14, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
      8'h50: g = {5'd30, 5'd17, 5'd17, 5'd30, 5'd16, 5'd16, 5'd16};
      8'h52: g = {5'd30, 5'd17, 5'd17, 5'd30, 5'd20, 5'd18, 5'd17};
      8'h53: g = {5'd15, 5'd16, 5'd16, 5'd14, 5'd1, 5'd1, 5'd30};
      8'h54: g = {5'd31, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4};
      8'h55: g = {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
      8'h56: g = {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd10, 5'd4};
      8'h57: g = {5'd17, 5'd17, 5'd17, 5'd21, 5'd21, 5'd21, 5'd10};
      8'h58: g = {5'd17, 5'd17, 5'd10, 5'd4, 5'd10, 5'd17, 5'd17};
      8'h59: g = {5'd17, 5'd17, 5'd10, 5'd4, 5'd4, 5'd4, 5'd4};
      8'h5A: g = {5'd31, 5'd1, 5'd2, 5'd4, 5'd8, 5'd16, 5'd31};
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

[design/sgtr_clip.sv]
// Cell rectangle builder: screen test and right/bottom clipping for one font dot.
module sgtr_clip #(
  parameter int COORD_BITS = 14
) (
  input  logic [sgtr_pkg::XW-1:0]      x,
  input  logic [sgtr_pkg::XW-1:0]      y,
  input  logic [sgtr_pkg::SCALE_W-1:0] scale,
  input  logic [COORD_BITS-1:0]        screen_width,
  input  logic [COORD_BITS-1:0]        screen_height,
  output sgtr_pkg::rect_t              rect
);
  import sgtr_pkg::*;

  logic [XW-1:0] sw_ext;
  logic [XW-1:0] sh_ext;
  logic [XW-1:0] r_raw;
  logic [XW-1:0] b_raw;

  // A cell is kept when its top-left corner lies on the screen.
  always_comb begin
    sw_ext      = XW'(screen_width);
    sh_ext      = XW'(screen_height);
    r_raw       = x + XW'(scale);
    b_raw       = y + XW'(scale);
    rect.hit    = (x < sw_ext) && (y < sh_ext);
    rect.left   = x;
    rect.top    = y;
    rect.right  = (r_raw > sw_ext) ? sw_ext : r_raw;
    rect.bottom = (b_raw > sh_ext) ? sh_ext : b_raw;
  end

endmodule

[design/scaled_glyph_text_rasterizer.sv]
// Top level of the scaled 5x7 glyph text rasterizer.
//
// Usage: each input item carries one character with its origin, scale and colour;
// new_text loads the pen with origin_x before the character is drawn. The block
// scans the 35 font dots of the glyph one per cycle while not stalled, top row
// first and leftmost dot first, and emits one clipped scale-by-scale rectangle per
// lit, on-screen dot. last_rect marks the final rectangle of a character; a
// character that draws nothing gives no result at all. The pen then advances by
// 7*scale, saturating at 65535.
// Flow: in_ready is high only between characters. Each character is taken in,
// its dots are scanned and its final rectangle is released before the next one
// can be taken. A rectangle is held back until the next lit dot is scanned or
// the scan ends, and only then is it moved into the output register.
// A stalled receiver (out_ready low) holds the output register and pauses the
// scan whenever a second rectangle is ready to leave.
// Reset (rst_n low at a clock edge) empties the block, clears the pen to zero and
// sets the screen to 640 by 480. Configuration writes complete without wait
// states at any time; they must be made only while no character is in flight.
module scaled_glyph_text_rasterizer #(
  parameter int COORD_BITS = 14
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Character items
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_character,
  input  logic                  in_new_text,
  input  logic [COORD_BITS-1:0] in_origin_x,
  input  logic [COORD_BITS-1:0] in_origin_y,
  input  logic [3:0]            in_scale,
  input  logic [31:0]           in_color,
  // Rectangle items
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COORD_BITS-1:0] out_rect_left,
  output logic [COORD_BITS-1:0] out_rect_top,
  output logic [COORD_BITS-1:0] out_rect_right,
  output logic [COORD_BITS-1:0] out_rect_bottom,
  output logic [31:0]           out_rect_color,
  output logic                  out_last_rect,
  // Configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import sgtr_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  localparam logic REG_SCREEN_WIDTH  = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;

  localparam logic [GX_W-1:0] GX_LAST = GX_W'(GLYPH_COLS - 1);
  localparam logic [GY_W-1:0] GY_LAST = GY_W'(GLYPH_ROWS - 1);

  logic [1:0]              state_r, state_nxt;
  logic [COORD_BITS-1:0]   screen_width_r;
  logic [COORD_BITS-1:0]   screen_height_r;
  logic [PEN_W-1:0]        pen_r;
  logic [GLYPH_CELLS-1:0]  glyph_r;
  logic [GX_W-1:0]         gx_r;
  logic [GY_W-1:0]         gy_r;
  logic [XW-1:0]           x_base_r;
  logic [XW-1:0]           x_acc_r;
  logic [XW-1:0]           y_acc_r;
  logic [SCALE_W-1:0]      scale_r;
  logic [31:0]             color_r;
  logic                    pend_valid_r;
  rect_t                   pend_r;
  logic                    out_valid_r;
  logic [COORD_BITS-1:0]   out_left_r, out_top_r, out_right_r, out_bottom_r;
  logic [31:0]             out_color_r;
  logic                    out_last_r;

  rect_t                   cand;
  logic                    cfg_wr;
  logic                    accept;
  logic                    hit;
  logic                    out_free;
  logic                    last_cell;
  logic                    stall;
  logic                    advance;
  logic                    push_mid;
  logic                    push_last;
  logic                    flush_done;
  logic [PEN_W-1:0]        pen_start;
  logic [PEN_W:0]          pen_sum;

  // Configuration registers: the register index is the word address bit.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_width_r  <= COORD_BITS'(640);
      screen_height_r <= COORD_BITS'(480);
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_SCREEN_WIDTH:  screen_width_r  <= pwdata[COORD_BITS-1:0];
        REG_SCREEN_HEIGHT: screen_height_r <= pwdata[COORD_BITS-1:0];
        default:           screen_width_r  <= screen_width_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_SCREEN_WIDTH:  prdata = 32'(screen_width_r);
      REG_SCREEN_HEIGHT: prdata = 32'(screen_height_r);
      default:           prdata = '0;
    endcase
  end

  // Rectangle of the dot under the scan position.
  sgtr_clip #(
    .COORD_BITS(COORD_BITS)
  ) u_clip (
    .x             (x_acc_r),
    .y             (y_acc_r),
    .scale         (scale_r),
    .screen_width  (screen_width_r),
    .screen_height (screen_height_r),
    .rect          (cand)
  );

  // Scan control. One rectangle is held back so that the last one can be marked.
  always_comb begin
    accept     = in_valid && in_ready;
    hit        = glyph_r[GLYPH_CELLS-1] && (scale_r != '0) && cand.hit;
    out_free   = !out_valid_r || out_ready;
    last_cell  = (gx_r == GX_LAST) && (gy_r == GY_LAST);
    stall      = (state_r == ST_SCAN) && hit && pend_valid_r && !out_free;
    advance    = (state_r == ST_SCAN) && !stall;
    push_mid   = (state_r == ST_SCAN) && hit && pend_valid_r && out_free;
    push_last  = (state_r == ST_FLUSH) && pend_valid_r && out_free;
    flush_done = (state_r == ST_FLUSH) && (!pend_valid_r || out_free);
    pen_start  = in_new_text ? PEN_W'(in_origin_x) : pen_r;
    pen_sum    = (PEN_W + 1)'(pen_start) +
                 ((PEN_W + 1)'(in_scale) * (PEN_W + 1)'(GLYPH_ADV));
  end

  // The multiply above is a 4-bit by constant product, seven times scale at most 105.
  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (accept) state_nxt = ST_SCAN;
      ST_SCAN:  if (advance && last_cell) state_nxt = ST_FLUSH;
      ST_FLUSH: if (flush_done) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pen_r        <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // The pen is advanced as soon as the character is taken in.
      if (accept) begin
        pen_r <= pen_sum[PEN_W] ? {PEN_W{1'b1}} : pen_sum[PEN_W-1:0];
      end
      if (advance && hit) begin
        pend_valid_r <= 1'b1;
      end else if (push_last) begin
        pend_valid_r <= 1'b0;
      end
      if (push_mid || push_last) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Scan position and coordinate accumulators; each scan step adds scale to x or to y.
  always_ff @(posedge clk) begin
    if (accept) begin
      glyph_r  <= glyph_bits(in_character);
      gx_r     <= '0;
      gy_r     <= '0;
      x_base_r <= XW'(pen_start);
      x_acc_r  <= XW'(pen_start);
      y_acc_r  <= XW'(in_origin_y);
      scale_r  <= in_scale;
      color_r  <= in_color;
    end else if (advance) begin
      glyph_r <= {glyph_r[GLYPH_CELLS-2:0], 1'b0};
      if (gx_r == GX_LAST) begin
        gx_r    <= '0;
        gy_r    <= gy_r + GY_W'(1);
        x_acc_r <= x_base_r;
        y_acc_r <= y_acc_r + XW'(scale_r);
      end else begin
        gx_r    <= gx_r + GX_W'(1);
        x_acc_r <= x_acc_r + XW'(scale_r);
      end
    end
  end

  // Held rectangle and output register payload.
  always_ff @(posedge clk) begin
    if (advance && hit) begin
      pend_r <= cand;
    end
    if (push_mid || push_last) begin
      out_left_r   <= pend_r.left[COORD_BITS-1:0];
      out_top_r    <= pend_r.top[COORD_BITS-1:0];
      out_right_r  <= pend_r.right[COORD_BITS-1:0];
      out_bottom_r <= pend_r.bottom[COORD_BITS-1:0];
      out_color_r  <= color_r;
      out_last_r   <= push_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_rect_left   = out_left_r;
  assign out_rect_top    = out_top_r;
  assign out_rect_right  = out_right_r;
  assign out_rect_bottom = out_bottom_r;
  assign out_rect_color  = out_color_r;
  assign out_last_rect   = out_last_r;

endmodule

[design/sgtr_checker.sv]
// Port checker for the glyph rasterizer, bound to the top level.
module sgtr_checker #(
  parameter int COORD_BITS = 14
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [COORD_BITS-1:0] out_rect_left,
  input logic [COORD_BITS-1:0] out_rect_top,
  input logic [COORD_BITS-1:0] out_rect_right,
  input logic [COORD_BITS-1:0] out_rect_bottom,
  input logic                  out_last_rect
);

  // A stalled rectangle stays on the port with its left, right, top and last flag unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_rect_left) &&
      $stable(out_rect_right) && $stable(out_rect_top) && $stable(out_last_rect))
    else $error("rectangle changed while stalled");

  // A character keeps the block busy for its scan.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("block ready again right after taking a character");

  // Every rectangle covers at least one pixel after clipping.
  a_rect_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_rect_right > out_rect_left) && (out_rect_bottom > out_rect_top))
    else $error("empty or inverted rectangle");

  // A rectangle that is not the last of its character never waits while the block is ready.
  a_last_before_next: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_rect |-> !in_ready)
    else $error("block ready while a character still has rectangles to give");

endmodule

bind scaled_glyph_text_rasterizer sgtr_checker #(
  .COORD_BITS(COORD_BITS)
) u_sgtr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_rect_left   (out_rect_left),
  .out_rect_top    (out_rect_top),
  .out_rect_right  (out_rect_right),
  .out_rect_bottom (out_rect_bottom),
  .out_last_rect   (out_last_rect)
);

[sim/scaled_glyph_text_rasterizer_tb.sv]
// Self-checking testbench for the scaled 5x7 glyph text rasterizer.
`timescale 1ns / 100ps

module scaled_glyph_text_rasterizer_tb;

  localparam int CW             = 14;
  localparam int MAX_COORD      = (1 << CW) - 1;
  localparam int PEN_MAX        = 65535;
  localparam int SETTLE_CYCLES  = 40;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int LIMIT_CYCLES   = 1000000;

  // Register addresses on the configuration port.
  localparam logic [2:0] REG_SCREEN_W = 3'd0;
  localparam logic [2:0] REG_SCREEN_H = 3'd4;

  // One character item as it appears on the input ports.
  typedef struct packed {
    logic [7:0]    character;
    logic          new_text;
    logic [CW-1:0] origin_x;
    logic [CW-1:0] origin_y;
    logic [3:0]    scale;
    logic [31:0]   color;
  } char_item_t;

  // One rectangle item as it appears on the output ports.
  typedef struct packed {
    logic [CW-1:0] left;
    logic [CW-1:0] top;
    logic [CW-1:0] right;
    logic [CW-1:0] bottom;
    logic [31:0]   color;
    logic          last;
  } box_t;

  // One line of the directed table: a screen change or a repeated character.
  typedef struct packed {
    bit            set_screen;
    logic [CW-1:0] new_w;
    logic [CW-1:0] new_h;
    char_item_t    item;
    logic [15:0]   reps;
    bit            typed;
    bit            typed_n;
    box_t          typed_box;
  } glyph_row_t;

  logic          clk;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  logic [7:0]    in_character = '0;
  logic          in_new_text = 1'b0;
  logic [CW-1:0] in_origin_x = '0;
  logic [CW-1:0] in_origin_y = '0;
  logic [3:0]    in_scale = '0;
  logic [31:0]   in_color = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic [CW-1:0] out_rect_left;
  logic [CW-1:0] out_rect_top;
  logic [CW-1:0] out_rect_right;
  logic [CW-1:0] out_rect_bottom;
  logic [31:0]   out_rect_color;
  logic          out_last_rect;
  logic          psel = 1'b0;
  logic          penable = 1'b0;
  logic          pwrite = 1'b0;
  logic [2:0]    paddr = '0;
  logic [31:0]   pwdata = '0;
  logic [31:0]   prdata;
  logic          pready;

  // Typed expectation travelling alongside the payload of the current item.
  bit   row_typed = 1'b0;
  bit   row_typed_n = 1'b0;
  box_t row_typed_box = '0;

  // Predictor state: pen position and the screen size last written.
  int   pen_pos = 0;
  int   scr_w = 640;
  int   scr_h = 480;
  box_t rect_queue[$];

  bit    gaps_on = 1'b1;
  bit    stalls_on = 1'b1;
  bit    hold_off_req = 1'b0;
  int    errors = 0;
  int    cycles = 0;
  int    chars_taken = 0;
  int    rects_checked = 0;
  int    screens_used = 1;
  int    hold_offs = 0;
  int    phase_count = 0;
  string glyph_set = "-:/0123456789ABCDEFGHILMNOPRSTUVWXYZ";

  char_item_t taken;
  box_t       got;
  box_t       want;
  int         queued_before;

  scaled_glyph_text_rasterizer #(.COORD_BITS(CW)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_character(in_character), .in_new_text(in_new_text),
    .in_origin_x(in_origin_x), .in_origin_y(in_origin_y),
    .in_scale(in_scale), .in_color(in_color),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_rect_left(out_rect_left), .out_rect_top(out_rect_top),
    .out_rect_right(out_rect_right), .out_rect_bottom(out_rect_bottom),
    .out_rect_color(out_rect_color), .out_last_rect(out_last_rect),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Font slot of a character code; slot 0 is the blank glyph.
  function automatic int font_slot(input logic [7:0] code);
    if (code == 8'h2D) return 1;
    if (code == 8'h3A) return 2;
    if (code == 8'h2F) return 3;
    if (code >= 8'h30 && code <= 8'h39) return 4 + (code - 8'h30);
    if (code >= 8'h41 && code <= 8'h49) return 14 + (code - 8'h41);
    if (code >= 8'h4C && code <= 8'h50) return 23 + (code - 8'h4C);
    if (code >= 8'h52 && code <= 8'h5A) return 28 + (code - 8'h52);
    return 0;
  endfunction

  // Glyph dots of a slot, top row in the upper bits, leftmost dot first.
  function automatic logic [34:0] font_dots(input int slot);
    case (slot)
      1:  return {5'd0, 5'd0, 5'd0, 5'd14, 5'd0, 5'd0, 5'd0};
      2:  return {5'd0, 5'd12, 5'd12, 5'd0, 5'd12, 5'd12, 5'd0};
      3:  return {5'd1, 5'd2, 5'd4, 5'd4, 5'd8, 5'd16, 5'd16};
      4:  return {5'd14, 5'd17, 5'd19, 5'd21, 5'd25, 5'd17, 5'd14};
      5:  return {5'd4, 5'd12, 5'd4, 5'd4, 5'd4, 5'd4, 5'd14};
      6:  return {5'd14, 5'd17, 5'd1, 5'd2, 5'd4, 5'd8, 5'd31};
      7:  return {5'd30, 5'd1, 5'd1, 5'd14, 5'd1, 5'd1, 5'd30};
      8:  return {5'd2, 5'd6, 5'd10, 5'd18, 5'd31, 5'd2, 5'd2};
      9:  return {5'd31, 5'd16, 5'd16, 5'd30, 5'd1, 5'd1, 5'd30};
      10: return {5'd6, 5'd8, 5'd16, 5'd30, 5'd17, 5'd17, 5'd14};
      11: return {5'd31, 5'd1, 5'd2, 5'd4, 5'd8, 5'd8, 5'd8};
      12: return {5'd14, 5'd17, 5'd17, 5'd14, 5'd17, 5'd17, 5'd14};
      13: return {5'd14, 5'd17, 5'd17, 5'd15, 5'd1, 5'd2, 5'd28};
      14: return {5'd14, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
      15: return {5'd30, 5'd17, 5'd17, 5'd30, 5'd17, 5'd17, 5'd30};
      16: return {5'd14, 5'd17, 5'd16, 5'd16, 5'd16, 5'd17, 5'd14};
      17: return {5'd28, 5'd18, 5'd17, 5'd17, 5'd17, 5'd18, 5'd28};
      18: return {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd31};
      19: return {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd16};
      20: return {5'd14, 5'd17, 5'd16, 5'd23, 5'd17, 5'd17, 5'd14};
      21: return {5'd17, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
      22: return {5'd14, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd14};
      23: return {5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd31};
      24: return {5'd17, 5'd27, 5'd21, 5'd21, 5'd17, 5'd17, 5'd17};
      25: return {5'd17, 5'd25, 5'd21, 5'd19, 5'd17, 5'd17, 5'd17};
      26: return {5'd14, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
      27: return {5'd30, 5'd17, 5'd17, 5'd30, 5'd16, 5'd16, 5'd16};
      28: return {5'd30, 5'd17, 5'd17, 5'd30, 5'd20, 5'd18, 5'd17};
      29: return {5'd15, 5'd16, 5'd16, 5'd14, 5'd1, 5'd1, 5'd30};
      30: return {5'd31, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4};
      31: return {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
      32: return {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd10, 5'd4};
      33: return {5'd17, 5'd17, 5'd17, 5'd21, 5'd21, 5'd21, 5'd10};
      34: return {5'd17, 5'd17, 5'd10, 5'd4, 5'd10, 5'd17, 5'd17};
      35: return {5'd17, 5'd17, 5'd10, 5'd4, 5'd4, 5'd4, 5'd4};
      36: return {5'd31, 5'd1, 5'd2, 5'd4, 5'd8, 5'd16, 5'd31};
      default: return '0;
    endcase
  endfunction

  // Works out the rectangles of one character and moves the pen on.
  task automatic paint_glyph(input char_item_t it);
    logic [34:0] dots;
    box_t        dot_box;
    box_t        held;
    bit          have;
    int          s, x, y, r, b, gx, gy, adv;
    have = 1'b0;
    held = '0;
    if (it.new_text) pen_pos = int'(it.origin_x);
    dots = font_dots(font_slot(it.character));
    s = int'(it.scale);
    if (s != 0) begin
      for (gy = 0; gy < sgtr_pkg::GLYPH_ROWS; gy++) begin
        for (gx = 0; gx < sgtr_pkg::GLYPH_COLS; gx++) begin
          if (dots[34 - gy * sgtr_pkg::GLYPH_COLS - gx]) begin
            x = pen_pos + gx * s;
            y = int'(it.origin_y) + gy * s;
            if (x < scr_w && y < scr_h) begin
              r = (x + s > scr_w) ? scr_w : x + s;
              b = (y + s > scr_h) ? scr_h : y + s;
              dot_box.left = x[CW-1:0];
              dot_box.top = y[CW-1:0];
              dot_box.right = r[CW-1:0];
              dot_box.bottom = b[CW-1:0];
              dot_box.color = it.color;
              dot_box.last = 1'b0;
              // Each rectangle waits until the next one shows it is not the last.
              if (have) rect_queue.push_back(held);
              held = dot_box;
              have = 1'b1;
            end
          end
        end
      end
    end
    if (have) begin
      held.last = 1'b1;
      rect_queue.push_back(held);
    end
    adv = pen_pos + sgtr_pkg::GLYPH_ADV * s;
    pen_pos = (adv > PEN_MAX) ? PEN_MAX : adv;
  endtask

  task automatic flag_field(input string name, input logic [31:0] exp_v,
                            input logic [31:0] act_v);
    $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    errors++;
  endtask

  // Monitor: predicts accepted characters and checks accepted rectangles.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles with %0d rectangles outstanding.",
               cycles, rect_queue.size());
      $display("RESULT: ERROR");
      $finish;
    end else if (rst_n) begin
      if (out_valid && out_ready) begin
        got = {out_rect_left, out_rect_top, out_rect_right, out_rect_bottom,
               out_rect_color, out_last_rect};
        if (rect_queue.size() == 0) begin
          $display("%0t ns: unexpected rectangle, expected none, actual %0h", $time, got);
          errors++;
        end else begin
          want = rect_queue.pop_front();
          rects_checked++;
          if (got.left !== want.left) flag_field("rect_left", want.left, got.left);
          if (got.top !== want.top) flag_field("rect_top", want.top, got.top);
          if (got.right !== want.right) flag_field("rect_right", want.right, got.right);
          if (got.bottom !== want.bottom)
            flag_field("rect_bottom", want.bottom, got.bottom);
          if (got.color !== want.color) flag_field("rect_color", want.color, got.color);
          if (got.last !== want.last) flag_field("last_rect", want.last, got.last);
        end
      end
      if (in_valid && in_ready) begin
        taken = {in_character, in_new_text, in_origin_x, in_origin_y, in_scale, in_color};
        queued_before = rect_queue.size();
        paint_glyph(taken);
        // A typed row replaces the prediction with the value read off by hand.
        if (row_typed) begin
          while (rect_queue.size() > queued_before) void'(rect_queue.pop_back());
          if (row_typed_n) rect_queue.push_back(row_typed_box);
        end
        chars_taken++;
      end
    end
  end

  // Receiver: random stalls per rectangle, plus a long hold-off on request.
  initial begin : receiver
    int w;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_offs++;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      w = stalls_on ? $urandom_range(0, 9) : 0;
      if (w > 0) begin
        out_ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Offers one character and waits until it is accepted; valid stays high after.
  task automatic send_char(input char_item_t it, input bit typed, input bit typed_n,
                           input box_t typed_box);
    int gap;
    gap = gaps_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_character <= it.character;
    in_new_text <= it.new_text;
    in_origin_x <= it.origin_x;
    in_origin_y <= it.origin_y;
    in_scale <= it.scale;
    in_color <= it.color;
    row_typed <= typed;
    row_typed_n <= typed_n;
    row_typed_box <= typed_box;
    do @(posedge clk); while (!in_ready);
    phase_count++;
  endtask

  // Stops offering items until every expected rectangle has come out.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (rect_queue.size() > 0) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Changes the screen size once the block has gone idle.
  task automatic set_screen(input int w, input int h);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    apb_write(REG_SCREEN_W, w & MAX_COORD);
    apb_write(REG_SCREEN_H, h & MAX_COORD);
    scr_w = w & MAX_COORD;
    scr_h = h & MAX_COORD;
    screens_used++;
  endtask

  // Coordinate picker that favours the screen edges.
  function automatic logic [CW-1:0] pick_coord(input int limit);
    int v;
    case ($urandom_range(0, 3))
      0: v = $urandom_range(0, MAX_COORD);
      1: v = $urandom_range(0, limit);
      2: v = limit + 4 - $urandom_range(0, 100);
      default: v = $urandom_range(0, 60);
    endcase
    if (v < 0) v = 0;
    if (v > MAX_COORD) v = MAX_COORD;
    return v[CW-1:0];
  endfunction

  function automatic logic [7:0] pick_char();
    if ($urandom_range(0, 99) < 85) return glyph_set[$urandom_range(0, glyph_set.len() - 1)];
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [3:0] pick_scale();
    if ($urandom_range(0, 11) == 0) return 4'd0;
    if ($urandom_range(0, 1) == 0) return 4'($urandom_range(1, 4));
    return 4'($urandom_range(1, 15));
  endfunction

  // A text: a first character that sets the pen, then characters that follow it.
  task automatic send_text();
    char_item_t it;
    int         len, k;
    len = $urandom_range(1, 8);
    it.new_text = 1'b1;
    it.origin_x = pick_coord(scr_w);
    it.origin_y = pick_coord(scr_h);
    it.scale = pick_scale();
    it.color = $urandom;
    for (k = 0; k < len; k++) begin
      it.character = pick_char();
      if (k > 0) begin
        // Now and then a text is broken by a fresh start or a change of scale.
        it.new_text = ($urandom_range(0, 19) == 0);
        it.origin_x = it.new_text ? pick_coord(scr_w) : CW'($urandom_range(0, MAX_COORD));
        if ($urandom_range(0, 9) == 0) it.scale = pick_scale();
      end
      send_char(it, 1'b0, 1'b0, '0);
    end
  endtask

  glyph_row_t glyph_rows[$];

  task automatic add_row(input logic [7:0] ch, input bit nt, input int ox, input int oy,
                         input int sc, input logic [31:0] col, input int reps,
                         input bit typed, input bit typed_n, input int tl, input int tt,
                         input int tr, input int tb);
    glyph_row_t row;
    row = '0;
    row.item = {ch, nt, ox[CW-1:0], oy[CW-1:0], sc[3:0], col};
    row.reps = 16'(reps);
    row.typed = typed;
    row.typed_n = typed_n;
    row.typed_box = {tl[CW-1:0], tt[CW-1:0], tr[CW-1:0], tb[CW-1:0], col, 1'b1};
    glyph_rows.push_back(row);
  endtask

  task automatic add_screen(input int w, input int h);
    glyph_row_t row;
    row = '0;
    row.set_screen = 1'b1;
    row.new_w = w[CW-1:0];
    row.new_h = h[CW-1:0];
    glyph_rows.push_back(row);
  endtask

  initial begin : stimulus
    int i, k, ph, w, h, target;
    bit paused;

    // Directed table, starting from the screen size after reset.
    add_row("-", 1, 638, 476, 1, 32'hFFFF_FFFF, 1, 1, 1, 639, 479, 640, 480);
    add_row("8", 1, 0, 0, 1, 32'h0000_0000, 1, 0, 0, 0, 0, 0, 0);
    add_row("W", 0, MAX_COORD, 5, 0, 32'h1234_5678, 1, 1, 0, 0, 0, 0, 0);
    add_row("J", 0, 0, 20, 3, 32'h0F0F_0F0F, 1, 1, 0, 0, 0, 0, 0);
    add_row(8'h00, 0, 0, 20, 15, 32'hF0F0_F0F0, 1, 1, 0, 0, 0, 0, 0);
    add_row(8'hFF, 0, 0, 20, 15, 32'h8000_0001, 1, 1, 0, 0, 0, 0, 0);
    add_row("q", 0, 0, 20, 2, 32'h7FFF_FFFE, 1, 1, 0, 0, 0, 0, 0);
    add_row("A", 1, 0, 480, 1, 32'h0000_00FF, 1, 1, 0, 0, 0, 0, 0);
    add_row("M", 1, 630, 470, 4, 32'hDEAD_BEEF, 1, 0, 0, 0, 0, 0, 0);
    add_row("A", 1, 100, 0, 0, 32'h0000_0001, 1, 1, 0, 0, 0, 0, 0);
    add_row("B", 0, 0, 10, 2, 32'h5555_AAAA, 1, 0, 0, 0, 0, 0, 0);
    add_row(":", 0, 0, 100, 15, 32'hAAAA_5555, 1, 0, 0, 0, 0, 0, 0);
    add_row("/", 0, 0, 300, 9, 32'h0123_4567, 1, 0, 0, 0, 0, 0, 0);
    add_row("0", 1, MAX_COORD, MAX_COORD, 15, 32'h89AB_CDEF, 1, 1, 0, 0, 0, 0, 0);
    add_row("Z", 1, 5, 200, 1, 32'hCAFE_F00D, 1, 0, 0, 0, 0, 0, 0);
    add_screen(MAX_COORD, MAX_COORD);
    add_row("M", 1, 16370, 16370, 15, 32'hA5A5_5A5A, 1, 0, 0, 0, 0, 0, 0);
    // Blank characters at full scale walk the pen well past the coordinate range.
    add_row(" ", 1, MAX_COORD, 0, 15, 32'h0, 1, 1, 0, 0, 0, 0, 0);
    add_row(" ", 0, 0, 0, 15, 32'h0, 30, 1, 0, 0, 0, 0, 0);
    add_row("8", 0, 0, 0, 1, 32'h1111_1111, 1, 1, 0, 0, 0, 0, 0);
    add_row("E", 1, 0, 0, 15, 32'h2222_2222, 1, 0, 0, 0, 0, 0, 0);
    add_screen(0, 0);
    add_row("H", 1, 0, 0, 1, 32'h3333_3333, 1, 1, 0, 0, 0, 0, 0);
    add_screen(5, 7);
    add_row("8", 1, 0, 0, 1, 32'h4444_4444, 1, 0, 0, 0, 0, 0, 0);
    add_row("B", 0, 0, 0, 1, 32'h6666_6666, 1, 1, 0, 0, 0, 0, 0);

    while (!rst_n) @(posedge clk);
    @(posedge clk);

    for (i = 0; i < glyph_rows.size(); i++) begin
      if (glyph_rows[i].set_screen) begin
        set_screen(glyph_rows[i].new_w, glyph_rows[i].new_h);
      end else begin
        for (k = 0; k < glyph_rows[i].reps; k++)
          send_char(glyph_rows[i].item, glyph_rows[i].typed, glyph_rows[i].typed_n,
                    glyph_rows[i].typed_box);
      end
    end

    // Random texts over several screen sizes and handshake patterns.
    for (ph = 0; ph < 6; ph++) begin
      target = 30;
      gaps_on = 1'b1;
      stalls_on = 1'b1;
      case (ph)
        0: begin
          w = 640;
          h = 480;
          gaps_on = 1'b0;
          stalls_on = 1'b0;
        end
        1: begin
          w = MAX_COORD;
          h = MAX_COORD;
        end
        2: begin
          w = $urandom_range(0, MAX_COORD);
          h = $urandom_range(0, MAX_COORD);
        end
        3: begin
          w = 0;
          h = 0;
          target = 10;
        end
        4: begin
          w = 64;
          h = 48;
        end
        default: begin
          w = $urandom_range(100, 1000);
          h = $urandom_range(60, 800);
        end
      endcase
      set_screen(w, h);
      phase_count = 0;
      paused = 1'b0;
      // On the full screen the receiver holds off while characters keep coming.
      if (ph == 1) hold_off_req = 1'b1;
      while (phase_count < target) begin
        if (ph == 2 && !paused && phase_count >= 20) begin
          drain();
          paused = 1'b1;
        end
        send_text();
      end
    end

    // Wind down: wait for every rectangle, then for the tail of the last scan.
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (rect_queue.size() != 0) begin
      $display("%0t ns: %0d rectangles never arrived", $time, rect_queue.size());
      errors++;
    end
    $display("Drew %0d characters into %0d checked rectangles across %0d screen sizes,",
             chars_taken, rects_checked, screens_used);
    $display("with random gaps and stalls, %0d long output hold-offs and %0d mismatches.",
             hold_offs, errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[scaled_glyph_text_rasterizer.f]
design/sgtr_pkg.sv
design/sgtr_clip.sv
design/scaled_glyph_text_rasterizer.sv
design/sgtr_checker.sv
sim/scaled_glyph_text_rasterizer_tb.sv
